// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the contact pair tracker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ASSERT_CLK(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("reset assertion failed");

`endif

// ===== hdl/cpet_pkg.sv =====
// ---------------------------------------------------------------------------
// cpet_pkg
// Types, constants and defaults shared by the contact pair tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cpet_pkg;

    // Default configuration
    localparam int DEF_MAX_COLLIDERS = 256;
    localparam int DEF_NUM_PROFILES  = 4;
    localparam int DEF_NUM_CHANNELS  = 4;

    // Field widths
    localparam int ID_W   = 8;
    localparam int SEL_W  = 2;
    localparam int MASK_W = 16;

    // Contact memory word layout
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_BITS - 1);

    // Register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [MASK_W-1:0] IGNORE_MASK_RESET = 16'h0001;
    localparam logic REG_IGNORE_MASK = 1'b0;  // register index, taken from paddr[2]

    // Contact event codes
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_BEGIN = 2'd1,
        EV_STAY  = 2'd2,
        EV_LEAVE = 2'd3
    } ev_t;

    // Request into the event decoder
    typedef struct packed {
        logic [SEL_W-1:0] src_profile;
        logic [SEL_W-1:0] src_channel;
        logic [SEL_W-1:0] dest_profile;
        logic [SEL_W-1:0] dest_channel;
        logic             overlap;
        logic             was;
    } pair_req_t;

    // Decoder result
    typedef struct packed {
        ev_t  src_event;
        ev_t  dest_event;
        logic now;
    } pair_res_t;

endpackage

`default_nettype wire

// ===== hdl/cpet_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// cpet_cfg_regs
// APB register block holding the ignore mask.
// ---------------------------------------------------------------------------
`default_nettype none

module cpet_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cpet_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cpet_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cpet_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [cpet_pkg::MASK_W-1:0]     ignore_mask
);
    import cpet_pkg::*;

    logic [MASK_W-1:0] mask_reg;
    logic              wr_en;
    logic              sel_mask;

    // Decode register index from the word address
    assign sel_mask = (paddr[2] == REG_IGNORE_MASK);
    assign wr_en    = psel && penable && pwrite && sel_mask;
    assign pready   = 1'b1;

    // Hold the mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= IGNORE_MASK_RESET;
        end else if (wr_en) begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (sel_mask) begin
            prdata = {{(APB_DATA_W - MASK_W){1'b0}}, mask_reg};
        end
    end

    assign ignore_mask = mask_reg;

endmodule

`default_nettype wire

// ===== hdl/cpet_contact_ram.sv =====
// ---------------------------------------------------------------------------
// cpet_contact_ram
// Single-port-write, single-port-read contact memory with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module cpet_contact_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                           aclk,
    input  wire logic                           we,
    input  wire logic [ADDR_W-1:0]              waddr,
    input  wire logic [cpet_pkg::WORD_BITS-1:0] wdata,
    input  wire logic                           re,
    input  wire logic [ADDR_W-1:0]              raddr,
    output logic      [cpet_pkg::WORD_BITS-1:0] rdata
);
    import cpet_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/cpet_event_logic.sv =====
// ---------------------------------------------------------------------------
// cpet_event_logic
// Ignore-mask evaluation and begin/stay/leave decode for one pair.
// ---------------------------------------------------------------------------
`default_nettype none

module cpet_event_logic #(
    parameter int NUM_PROFILES = cpet_pkg::DEF_NUM_PROFILES,
    parameter int NUM_CHANNELS = cpet_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic [cpet_pkg::MASK_W-1:0] ignore_mask,
    input  wire cpet_pkg::pair_req_t         req,
    output cpet_pkg::pair_res_t              res
);
    import cpet_pkg::*;

    localparam logic [SEL_W:0] PROF_LIM = (SEL_W + 1)'(NUM_PROFILES);
    localparam logic [SEL_W:0] CHAN_LIM = (SEL_W + 1)'(NUM_CHANNELS);

    logic src_reacts;
    logic dest_reacts;
    ev_t  ev;

    // Each side reacts unless its profile ignores the other side's channel
    assign src_reacts = ({1'b0, req.src_profile} < PROF_LIM) &&
                        ({1'b0, req.dest_channel} < CHAN_LIM) &&
                        !ignore_mask[{req.src_profile, req.dest_channel}];
    assign dest_reacts = ({1'b0, req.dest_profile} < PROF_LIM) &&
                         ({1'b0, req.src_channel} < CHAN_LIM) &&
                         !ignore_mask[{req.dest_profile, req.src_channel}];

    // Decode the contact transition
    always_comb begin
        ev      = EV_NONE;
        res.now = 1'b0;
        if (src_reacts || dest_reacts) begin
            if (req.overlap) begin
                res.now = 1'b1;
                ev      = req.was ? EV_STAY : EV_BEGIN;
            end else begin
                ev = req.was ? EV_LEAVE : EV_NONE;
            end
        end
        res.src_event  = src_reacts ? ev : EV_NONE;
        res.dest_event = dest_reacts ? ev : EV_NONE;
    end

endmodule

`default_nettype wire

// ===== hdl/contact_pair_event_tracker.sv =====
// ---------------------------------------------------------------------------
// contact_pair_event_tracker
// Tracks contact state of collider pairs and reports begin, stay and leave.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one candidate pair per transfer; m_* returns one event
//   transfer per pair, in order. The ignore mask is written over the APB
//   port at byte address 0 while the block is idle.
//   For each pair the block first issues the contact memory read, then takes
//   the read data, decodes the events and writes the word back. This
//   read-modify-write on the single contact memory means a new pair is taken
//   only once the previous pair's word has been written back. m_tvalid comes
//   from the output register, loaded in the ST_READ state after the transfer.
//   Contact bits live at the symmetric position (min id, max id) only, one
//   word read and written per pair.
//   After reset the block clears all MAX_COLLIDERS * ceil(MAX_COLLIDERS/32)
//   words of the contact memory (2048 by default) one word a cycle, with
//   s_tready low; APB writes are taken throughout.
//   The output register frees the input side: a new pair is taken while a
//   result waits. If m_tready stays low, the next pair holds in its decode
//   cycle until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module contact_pair_event_tracker #(
    parameter int MAX_COLLIDERS = cpet_pkg::DEF_MAX_COLLIDERS,
    parameter int NUM_PROFILES  = cpet_pkg::DEF_NUM_PROFILES,
    parameter int NUM_CHANNELS  = cpet_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // tdata: src_id[7:0], dest_id[15:8], src_profile[17:16], src_channel[19:18],
    //        dest_profile[21:20], dest_channel[23:22], overlap[24], zero[31:25]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,
    // tdata: src_event[1:0], dest_event[3:2], was_touching[4],
    //        now_touching[5], zero[7:6]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [7:0]                      m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cpet_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cpet_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cpet_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import cpet_pkg::*;

    localparam int ROW_WORDS = (MAX_COLLIDERS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH     = MAX_COLLIDERS * ROW_WORDS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int RED_W     = 16;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [BIT_W-1:0]     bit_reg;
    pair_req_t            req_reg;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;

    logic [MASK_W-1:0]    ignore_mask;
    logic [ID_W-1:0]      in_src_id, in_dest_id, src_red, dest_red, lo_id, hi_id;
    logic [ADDR_W-1:0]    in_addr;
    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] upd_word;
    pair_req_t            cur_req;
    pair_res_t            cur_res;

    // Register block
    cpet_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .ignore_mask (ignore_mask)
    );

    // Reduce ids modulo the collider count by conditional subtraction
    function automatic logic [ID_W-1:0] reduce_id(input logic [ID_W-1:0] id);
        logic [RED_W-1:0] v;
        v = RED_W'(id);
        for (int k = 2; k >= 0; k--) begin
            if (v >= RED_W'(MAX_COLLIDERS << k)) begin
                v = v - RED_W'(MAX_COLLIDERS << k);
            end
        end
        return v[ID_W-1:0];
    endfunction

    assign in_src_id  = s_tdata[7:0];
    assign in_dest_id = s_tdata[15:8];
    assign src_red    = reduce_id(in_src_id);
    assign dest_red   = reduce_id(in_dest_id);

    // Use the canonical position row = lower id, column = higher id
    assign lo_id   = (src_red < dest_red) ? src_red : dest_red;
    assign hi_id   = (src_red < dest_red) ? dest_red : src_red;
    assign in_addr = ADDR_W'(ADDR_W'(lo_id) * ADDR_W'(ROW_WORDS)) +
                     ADDR_W'(hi_id >> BIT_W);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_READ) && out_free;

    // Decode the pair against the stored contact bit
    always_comb begin
        cur_req     = req_reg;
        cur_req.was = ram_rdata[bit_reg];
    end

    cpet_event_logic #(
        .NUM_PROFILES (NUM_PROFILES),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_event (
        .ignore_mask (ignore_mask),
        .req         (cur_req),
        .res         (cur_res)
    );

    // Merge the new contact bit into the word
    always_comb begin
        upd_word          = ram_rdata;
        upd_word[bit_reg] = cur_res.now;
    end

    // Memory write: clearing sweep or write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = upd_word;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (out_load) begin
            ram_we = 1'b1;
        end
    end

    cpet_contact_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // State, captured pair and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept) begin
                addr_reg             <= in_addr;
                bit_reg              <= LAST_BIT - hi_id[BIT_W-1:0];
                req_reg.src_profile  <= s_tdata[17:16];
                req_reg.src_channel  <= s_tdata[19:18];
                req_reg.dest_profile <= s_tdata[21:20];
                req_reg.dest_channel <= s_tdata[23:22];
                req_reg.overlap      <= s_tdata[24];
                req_reg.was          <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {2'b00, cur_res.now, cur_req.was,
                                 cur_res.dest_event, cur_res.src_event};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `ASSERT_ALWAYS(a_reset_starts_clear, aclk, !aresetn |=> (state_reg == ST_CLEAR))
    `ASSERT_CLK(a_clear_blocks_input, aclk, aresetn, (state_reg == ST_CLEAR) |-> !s_tready)
    `ASSERT_CLK(a_accept_reads, aclk, aresetn, accept |=> (state_reg == ST_READ))
    `ASSERT_CLK(a_stall_holds_read, aclk, aresetn,
        (state_reg == ST_READ && !out_free) |=> (state_reg == ST_READ))
    `ASSERT_CLK(a_writeback_with_result, aclk, aresetn,
        (ram_we && state_reg != ST_CLEAR) |-> out_load)

endmodule

`default_nettype wire
